// ===== hdl/spimd_pkg.sv =====
// shared types and constants for the spi master with clock divider
package spimd_pkg;

    localparam int WORD_BITS = 32;
    localparam int DIV_BITS  = 16;
    localparam int IDX_BITS  = $clog2(WORD_BITS);

    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // register byte addresses
    localparam logic [ADDR_BITS-1:0] REG_CLOCK_DIVIDE = 3'd0;

    // input item, first field in the highest bits
    typedef struct packed {
        logic                 serial_in;
        logic [IDX_BITS-1:0]  last_bit_index;
        logic [WORD_BITS-1:0] tx_word;
        logic                 start_req;
        logic                 run_enable;
    } t_in_item;

    // result item, first field in the highest bits
    typedef struct packed {
        logic                 serial_out;
        logic                 serial_clock;
        logic                 chip_select_n;
        logic                 done_res;
        logic [WORD_BITS-1:0] rx_word;
    } t_out_item;

    localparam int IN_BITS  = $bits(t_in_item);
    localparam int OUT_BITS = $bits(t_out_item);
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ===== hdl/spi_master_with_clock_divider.sv =====
// top level of the mode 3 spi master with clock divider
//
// usage
//  - each transfer on the slave stream is one system tick of the spi master;
//    every accepted tick produces exactly one result transfer on the master
//    stream, in order
//  - slave tdata carries run_enable, start_req, tx_word, last_bit_index and
//    serial_in; master tdata carries rx_word, done_res, chip_select_n,
//    serial_clock and serial_out
//  - the apb port holds clock_divide at byte address 0 (serial clock
//    half-period in ticks minus one); write it only while the block is idle
//  - a tick accepted from the slave stream is registered at the input stage,
//    stepped through the sequencer when the output register is free or
//    draining, and its result then lands in the output register
//  - throughput: one tick per cycle while the master stream does not stall;
//    the sequencer state and the divider advance once per tick, so back-to-back ticks stream without gaps
//  - reset (synchronous, active low) clears both stages, the divider,
//    the sequencer and clock_divide; pins come up idle high
//  - when the receiver stalls the result stays in the output register,
//    one further tick is held in the input stage, and then s_axis_tready
//    drops until the master side moves again
module spi_master_with_clock_divider (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // slave stream
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // run_enable[0], start_req[1], tx_word[33:2], last_bit_index[38:34],
    // serial_in[39]
    input  logic [spimd_pkg::IN_TDATA_BITS-1:0]      s_axis_tdata,
    // master stream
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // rx_word[31:0], done_res[32], chip_select_n[33], serial_clock[34],
    // serial_out[35], zero fill[39:36]
    output logic [spimd_pkg::OUT_TDATA_BITS-1:0]     m_axis_tdata,
    // configuration
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [spimd_pkg::ADDR_BITS-1:0]          paddr,
    input  logic [spimd_pkg::DATA_BITS-1:0]          pwdata,
    output logic [spimd_pkg::DATA_BITS-1:0]          prdata,
    output logic                                     pready
);
    import spimd_pkg::*;

    logic [DIV_BITS-1:0] r_clock_divide;
    logic                r_in_valid;
    t_in_item            r_in_item;
    logic                r_out_valid;
    t_out_item           r_out_item;
    logic                step;
    logic                in_take;
    logic                tick_pending;
    t_out_item           core_result;

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_divide <= '0;
        end else if (psel && penable && pwrite && (paddr == REG_CLOCK_DIVIDE)) begin
            r_clock_divide <= pwdata[DIV_BITS-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_CLOCK_DIVIDE) begin
            prdata = DATA_BITS'(r_clock_divide);
        end
    end

    // a tick steps the sequencer when the output register is free or draining
    assign step          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || step;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= t_in_item'(s_axis_tdata[IN_BITS-1:0]);
        end
    end

    spimd_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_run_enable   (r_in_item.run_enable),
        .i_clock_divide (r_clock_divide),
        .o_tick_pending (tick_pending)
    );

    spimd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_in_item),
        .i_tick_pending (tick_pending),
        .o_result       (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_BITS'(r_out_item);

endmodule

// ===== hdl/spimd_div.sv =====
// serial clock divider with one-tick delayed pulse
module spimd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_step,
    input  logic                          i_run_enable,
    input  logic [spimd_pkg::DIV_BITS-1:0] i_clock_divide,
    output logic                          o_tick_pending
);
    import spimd_pkg::*;

    logic [DIV_BITS-1:0] r_divide_count;
    logic [DIV_BITS-1:0] n_divide_count;
    logic                r_tick_pending;
    logic                n_tick_pending;

    always_comb begin
        n_divide_count = r_divide_count;
        n_tick_pending = r_tick_pending;
        if (!i_run_enable) begin
            n_divide_count = '0;
            n_tick_pending = 1'b0;
        end else if (r_divide_count != i_clock_divide) begin
            // wraps when the divide value was lowered below the count
            n_divide_count = r_divide_count + DIV_BITS'(1);
            n_tick_pending = 1'b0;
        end else begin
            n_divide_count = '0;
            n_tick_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_count <= '0;
            r_tick_pending <= 1'b0;
        end else if (i_step) begin
            r_divide_count <= n_divide_count;
            r_tick_pending <= n_tick_pending;
        end
    end

    assign o_tick_pending = r_tick_pending;

endmodule

// ===== hdl/spimd_core.sv =====
// mode 3 transfer sequencer: alignment, bit shifting and pin state
module spimd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  spimd_pkg::t_in_item  i_item,
    input  logic                 i_tick_pending,
    output spimd_pkg::t_out_item o_result
);
    import spimd_pkg::*;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ALIGN  = 3'd1;
    localparam logic [2:0] PH_HIGH   = 3'd2;
    localparam logic [2:0] PH_LOW    = 3'd3;
    localparam logic [2:0] PH_FINISH = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;

    localparam logic [IDX_BITS-1:0] TOP_INDEX = IDX_BITS'(WORD_BITS - 1);

    logic [2:0]           r_phase,       n_phase;
    logic [WORD_BITS-1:0] r_tx_shift,    n_tx_shift;
    logic [IDX_BITS-1:0]  r_align_count, n_align_count;
    logic [IDX_BITS-1:0]  r_bits_left,   n_bits_left;
    logic [WORD_BITS-1:0] r_rx_shift,    n_rx_shift;
    logic                 r_done,        n_done;
    logic                 r_select,      n_select;
    logic                 r_sck,         n_sck;
    logic                 r_mosi,        n_mosi;

    always_comb begin
        n_phase       = r_phase;
        n_tx_shift    = r_tx_shift;
        n_align_count = r_align_count;
        n_bits_left   = r_bits_left;
        n_rx_shift    = r_rx_shift;
        n_done        = r_done;
        n_select      = r_select;
        n_sck         = r_sck;
        n_mosi        = r_mosi;
        if (!i_item.run_enable) begin
            n_phase       = PH_IDLE;
            n_tx_shift    = '0;
            n_align_count = '0;
            n_bits_left   = '0;
            n_rx_shift    = '0;
            n_done        = 1'b0;
            n_select      = 1'b1;
            n_sck         = 1'b1;
            n_mosi        = 1'b1;
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_select = 1'b1;
                    n_sck    = 1'b1;
                    n_mosi   = 1'b1;
                    if (i_item.start_req) begin
                        n_phase       = PH_ALIGN;
                        n_done        = 1'b0;
                        n_select      = 1'b0;
                        n_tx_shift    = i_item.tx_word;
                        n_align_count = i_item.last_bit_index;
                        n_bits_left   = i_item.last_bit_index;
                        n_rx_shift    = '0;
                    end
                end
                PH_ALIGN: begin
                    // left-justify one place per tick
                    if (r_align_count >= TOP_INDEX) begin
                        n_phase = PH_HIGH;
                    end else begin
                        n_tx_shift    = {r_tx_shift[WORD_BITS-2:0], 1'b0};
                        n_align_count = r_align_count + IDX_BITS'(1);
                    end
                end
                PH_HIGH: begin
                    // falling edge drives mosi
                    if (i_tick_pending) begin
                        n_phase = PH_LOW;
                        n_sck   = 1'b0;
                        n_mosi  = r_tx_shift[WORD_BITS-1];
                    end
                end
                PH_LOW: begin
                    // rising edge samples miso
                    if (i_tick_pending) begin
                        if (r_bits_left == '0) begin
                            n_phase = PH_FINISH;
                        end else begin
                            n_phase     = PH_HIGH;
                            n_bits_left = r_bits_left - IDX_BITS'(1);
                            n_tx_shift  = {r_tx_shift[WORD_BITS-2:0], 1'b0};
                        end
                        n_sck      = 1'b1;
                        n_rx_shift = {r_rx_shift[WORD_BITS-2:0], i_item.serial_in};
                    end
                end
                PH_FINISH: begin
                    if (i_tick_pending) begin
                        n_phase  = PH_END;
                        n_select = 1'b1;
                        n_sck    = 1'b1;
                        n_mosi   = 1'b0;
                    end
                end
                PH_END: begin
                    if (i_tick_pending) begin
                        n_phase = PH_IDLE;
                        n_done  = 1'b1;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tx_shift    <= '0;
            r_align_count <= '0;
            r_bits_left   <= '0;
            r_rx_shift    <= '0;
            r_done        <= 1'b0;
            r_select      <= 1'b1;
            r_sck         <= 1'b1;
            r_mosi        <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_tx_shift    <= n_tx_shift;
            r_align_count <= n_align_count;
            r_bits_left   <= n_bits_left;
            r_rx_shift    <= n_rx_shift;
            r_done        <= n_done;
            r_select      <= n_select;
            r_sck         <= n_sck;
            r_mosi        <= n_mosi;
        end
    end

    // the result of a tick is the state it leaves behind
    always_comb begin
        o_result.rx_word       = n_rx_shift;
        o_result.done_res      = n_done;
        o_result.chip_select_n = n_select;
        o_result.serial_clock  = n_sck;
        o_result.serial_out    = n_mosi;
    end

endmodule

// ===== bench/spi_master_with_clock_divider_tb.sv =====
// testbench for the spi master with clock divider: streamed ticks checked against a cycle model
`timescale 1ns / 1ps
module spi_master_with_clock_divider_tb;
    import spimd_pkg::*;

    // cycles with no transfer on either stream before the run is declared hung
    localparam int QUIET_LIMIT = 4000;
    // length of the forced receiver hold-off
    localparam int LONG_HOLD   = 150;

    // sequencer phases of the spi master
    typedef enum logic [2:0] {
        SEQ_IDLE, SEQ_ALIGN, SEQ_HIGH, SEQ_LOW, SEQ_FINISH, SEQ_END
    } t_spi_phase;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // run_enable[0], start_req[1], tx_word[33:2], last_bit_index[38:34], serial_in[39]
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // rx_word[31:0], done_res[32], chip_select_n[33], serial_clock[34], serial_out[35]
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [ADDR_BITS-1:0]      paddr         = '0;
    logic [DATA_BITS-1:0]      pwdata        = '0;
    logic [DATA_BITS-1:0]      prdata;
    logic                      pready;

    spi_master_with_clock_divider dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ticks waiting to be offered, and pin states predicted for accepted ticks
    t_in_item  tick_q[$];
    t_out_item spi_outputs_q[$];

    int ticks_queued    = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_requests   = 0;
    int holds_seen      = 0;
    int hold_left       = 0;
    int mismatches      = 0;
    int quiet_cycles    = 0;
    logic in_fire       = 1'b0;

    // cycle model of the spi master
    logic [DIV_BITS-1:0]  div_limit;
    logic [DIV_BITS-1:0]  div_count;
    logic                 tick_due;
    t_spi_phase           spi_phase;
    logic [WORD_BITS-1:0] tx_sr;
    logic [WORD_BITS-1:0] rx_sr;
    logic [IDX_BITS-1:0]  align_idx;
    logic [IDX_BITS-1:0]  bits_left;
    logic                 done_q;
    logic                 cs_n_q;
    logic                 sck_q;
    logic                 mosi_q;

    function void clear_spi_model();
        div_count = '0;
        tick_due  = 1'b0;
        spi_phase = SEQ_IDLE;
        tx_sr     = '0;
        align_idx = '0;
        bits_left = '0;
        rx_sr     = '0;
        done_q    = 1'b0;
        cs_n_q    = 1'b1;
        sck_q     = 1'b1;
        mosi_q    = 1'b1;
    endfunction

    // advance the model by one system tick and return the pins it shows
    function automatic t_out_item step_spi_model(input t_in_item it);
        logic      pulse;
        t_out_item res;
        pulse = 1'b0;
        if (!it.run_enable) begin
            clear_spi_model();
        end else begin
            // divider pulses when the count matches, wrapping if it was left above the limit
            if (div_count != div_limit) begin
                div_count = div_count + 1'b1;
            end else begin
                div_count = '0;
                pulse     = 1'b1;
            end
            case (spi_phase)
                SEQ_IDLE: begin
                    cs_n_q = 1'b1;
                    sck_q  = 1'b1;
                    mosi_q = 1'b1;
                    if (it.start_req) begin
                        spi_phase = SEQ_ALIGN;
                        done_q    = 1'b0;
                        cs_n_q    = 1'b0;
                        tx_sr     = it.tx_word;
                        align_idx = it.last_bit_index;
                        bits_left = it.last_bit_index;
                        rx_sr     = '0;
                    end
                end
                SEQ_ALIGN: begin
                    // left-justify, one shift per tick
                    if (align_idx >= IDX_BITS'(WORD_BITS - 1)) begin
                        spi_phase = SEQ_HIGH;
                    end else begin
                        tx_sr     = tx_sr << 1;
                        align_idx = align_idx + 1'b1;
                    end
                end
                SEQ_HIGH: begin
                    if (tick_due) begin
                        spi_phase = SEQ_LOW;
                        sck_q     = 1'b0;
                        mosi_q    = tx_sr[WORD_BITS-1];
                    end
                end
                SEQ_LOW: begin
                    if (tick_due) begin
                        if (bits_left == '0) begin
                            spi_phase = SEQ_FINISH;
                        end else begin
                            spi_phase = SEQ_HIGH;
                            bits_left = bits_left - 1'b1;
                            tx_sr     = tx_sr << 1;
                        end
                        sck_q = 1'b1;
                        rx_sr = {rx_sr[WORD_BITS-2:0], it.serial_in};
                    end
                end
                SEQ_FINISH: begin
                    if (tick_due) begin
                        spi_phase = SEQ_END;
                        cs_n_q    = 1'b1;
                        sck_q     = 1'b1;
                        mosi_q    = 1'b0;
                    end
                end
                SEQ_END: begin
                    if (tick_due) begin
                        spi_phase = SEQ_IDLE;
                        done_q    = 1'b1;
                    end
                end
                default: begin
                    spi_phase = SEQ_IDLE;
                end
            endcase
            tick_due = pulse;
        end
        res.rx_word       = rx_sr;
        res.done_res      = done_q;
        res.chip_select_n = it.run_enable ? cs_n_q : 1'b1;
        res.serial_clock  = it.run_enable ? sck_q : 1'b1;
        res.serial_out    = it.run_enable ? mosi_q : 1'b1;
        return res;
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            if (mismatches < 10) begin
                $display("mismatch on %s: expected %h, got %h", what, want, got);
            end
            mismatches++;
        end
    endtask

    // sender: offers the next tick at the falling edge, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_fire || !s_axis_tvalid) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_axis_tdata  <= IN_TDATA_BITS'(tick_q.pop_front());
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (holds_seen != hold_requests) begin
                holds_seen = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // monitor: checks result transfers, runs the model on accepted ticks, watches for a hang
    always @(posedge i_clk) begin : monitor
        t_out_item got_pins;
        t_out_item want_pins;
        logic      out_fire;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            // results first, so a tick accepted at this edge cannot hide a stray result
            if (m_axis_tvalid && m_axis_tready) begin
                out_fire = 1'b1;
                got_pins = t_out_item'(m_axis_tdata[OUT_BITS-1:0]);
                if (spi_outputs_q.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("result transfer with nothing expected: %h", m_axis_tdata);
                    end
                    mismatches++;
                end else begin
                    want_pins = spi_outputs_q.pop_front();
                    compare_field("rx_word", want_pins.rx_word, got_pins.rx_word);
                    compare_field("done_res", want_pins.done_res, got_pins.done_res);
                    compare_field("chip_select_n", want_pins.chip_select_n,
                                  got_pins.chip_select_n);
                    compare_field("serial_clock", want_pins.serial_clock,
                                  got_pins.serial_clock);
                    compare_field("serial_out", want_pins.serial_out, got_pins.serial_out);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                in_fire = 1'b1;
                spi_outputs_q.push_back(
                    step_spi_model(t_in_item'(s_axis_tdata[IN_BITS-1:0])));
            end
            quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("spi_master_with_clock_divider test failed");
                $finish;
            end
        end
    end

    task automatic push_tick(input logic run, input logic start, input logic [WORD_BITS-1:0] word,
                             input logic [IDX_BITS-1:0] idx, input logic miso);
        t_in_item it;
        it.run_enable     = run;
        it.start_req      = start;
        it.tx_word        = word;
        it.last_bit_index = idx;
        it.serial_in      = miso;
        tick_q.push_back(it);
        ticks_queued++;
    endtask

    // one start followed by enough ticks to finish the transfer and settle in idle;
    // start_req may be repeated while surely busy, and cut >= 0 clears the block mid-way
    task automatic push_transfer(input logic [WORD_BITS-1:0] word,
                                 input logic [IDX_BITS-1:0] idx, input int div,
                                 input int busy_start_pct, input int cut);
        int busy_min;
        int total;
        busy_min = (WORD_BITS - idx) + (2 * idx + 1) * (div + 1);
        total    = (WORD_BITS - idx) + (2 * idx + 4) * (div + 1) + div + 2 + $urandom_range(3);
        push_tick(1'b1, 1'b1, word, idx, 1'($urandom));
        for (int k = 0; k < total; k++) begin
            if (k == cut) begin
                push_tick(1'b0, 1'($urandom), $urandom, IDX_BITS'($urandom), 1'($urandom));
                k = total;
            end else begin
                push_tick(1'b1, (k < busy_min) && ($urandom_range(99) < busy_start_pct),
                          $urandom, IDX_BITS'($urandom), 1'($urandom));
            end
        end
    endtask

    // mostly complete transfers with random content, some noise ticks and aborts in between
    task automatic random_transfers(input int div, input int count);
        int first;
        first = ticks_queued;
        while (ticks_queued - first < count) begin
            if ($urandom_range(5) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    push_tick(1'($urandom), 1'b0, $urandom, IDX_BITS'($urandom), 1'($urandom));
                end
            end
            push_transfer($urandom, IDX_BITS'($urandom), div,
                          ($urandom_range(3) == 0) ? 30 : 0,
                          ($urandom_range(11) == 0) ? int'($urandom_range(80)) : -1);
        end
    endtask

    // sender stops until every predicted result has been seen
    task automatic wait_for_results();
        while (tick_q.size() != 0 || s_axis_tvalid || spi_outputs_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    // apb write of clock_divide, then a read back
    task automatic program_divider(input logic [DIV_BITS-1:0] value);
        logic [DATA_BITS-1:0] readback;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_CLOCK_DIVIDE;
        pwdata  <= DATA_BITS'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        div_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        compare_field("clock_divide read back", 32'(value), readback);
    endtask

    initial begin
        div_limit = '0;
        clear_spi_model();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset divider, no idling
        push_tick(1'b0, 1'b1, '1, '1, 1'b1);                // cleared with every other bit high
        push_tick(1'b1, 1'b0, '0, '0, 1'b0);
        push_transfer(32'hFFFF_FFFF, 5'd31, 0, 100, -1);    // full word, start held while busy
        push_transfer(32'h0000_0000, 5'd0, 0, 0, -1);       // single bit, longest alignment
        push_transfer(32'hA5C3_0F96, 5'd15, 0, 0, 20);      // cleared in the middle
        wait_for_results();

        // slow serial clock, no idling
        program_divider(16'd1);
        random_transfers(1, 150);
        wait_for_results();

        // fastest serial clock, sender mostly idle
        program_divider(16'd0);
        sender_idle_pct = 65;
        random_transfers(0, 150);
        wait_for_results();

        // receiver mostly stalled, plus one long hold-off while ticks keep coming
        program_divider(16'd2);
        sender_idle_pct = 0;
        stall_pct       = 65;
        random_transfers(2, 150);
        hold_requests++;
        wait_for_results();

        // both sides idle now and then, sender pauses half-way until all results are in
        program_divider(DIV_BITS'($urandom_range(3)));
        sender_idle_pct = 12;
        stall_pct       = 12;
        random_transfers(int'(div_limit), 70);
        wait_for_results();
        random_transfers(int'(div_limit), 70);
        wait_for_results();

        // largest divider: the count climbs without a pulse mid-transfer, then the
        // limit is lowered below it and the count keeps climbing with no pulse
        sender_idle_pct = 0;
        stall_pct       = 0;
        program_divider('1);
        repeat (3) push_tick(1'b1, 1'b0, '0, '0, 1'($urandom));
        push_tick(1'b1, 1'b1, $urandom, 5'd2, 1'($urandom));
        repeat (60) push_tick(1'b1, 1'b0, $urandom, IDX_BITS'($urandom), 1'($urandom));
        wait_for_results();
        program_divider(16'd3);
        repeat (60) begin
            push_tick(1'b1, 1'b0, $urandom, IDX_BITS'($urandom), 1'($urandom));
        end
        // clear the stuck transfer, then normal traffic at the new divider
        push_tick(1'b0, 1'b0, $urandom, IDX_BITS'($urandom), 1'($urandom));
        random_transfers(3, 20);
        wait_for_results();

        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && spi_outputs_q.size() == 0) begin
            $display("spi_master_with_clock_divider test passed");
        end else begin
            $display("spi_master_with_clock_divider test failed");
        end
        $finish;
    end

endmodule
